>>> src/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg: shared constants and types for the decimal palindrome checker
// Digit sizing, BCD correction constants and the state encodings.
// ----------------------------------------------------------------------------
package dpc_pkg;

    localparam int unsigned NUMBER_WIDTH_DEF = 64;
    localparam int unsigned DIGIT_W          = 4;

    // double-dabble correction: digits of 5 and up get 3 added before the shift
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ_ADD = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_ZERO    = 4'd0;

    // decimal digits needed for a w-bit unsigned value: ceil(w * log10(2))
    function automatic int unsigned dec_digits(input int unsigned w);
        return (w * 30103 + 99999) / 100000;
    endfunction

    typedef enum logic [2:0] {
        CV_IDLE = 3'b001,
        CV_RUN  = 3'b010,
        CV_DONE = 3'b100
    } t_cv_state;

    typedef enum logic [3:0] {
        MR_IDLE = 4'b0001,
        MR_NORM = 4'b0010,
        MR_CMP  = 4'b0100,
        MR_DONE = 4'b1000
    } t_mr_state;

endpackage

>>> src/dpc_bin2bcd.sv
// ----------------------------------------------------------------------------
// dpc_bin2bcd: serial binary to BCD converter
// Shift-and-add-3, one input bit per cycle.
// ----------------------------------------------------------------------------
module dpc_bin2bcd #(
    parameter int unsigned NUMBER_WIDTH = dpc_pkg::NUMBER_WIDTH_DEF,
    parameter int unsigned NUM_DIGITS   = dpc_pkg::dec_digits(NUMBER_WIDTH)
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [NUMBER_WIDTH-1:0]                  i_number,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [NUM_DIGITS*dpc_pkg::DIGIT_W-1:0]   o_bcd
);
    import dpc_pkg::*;

    localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;
    localparam int unsigned CNT_W = $clog2(NUMBER_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUMBER_WIDTH - 1);

    t_cv_state          r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [NUMBER_WIDTH-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [BCD_W-1:0]   adj;

    // add-3 on every digit, independent per digit
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN) begin
                adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_ADJ_ADD;
            end else begin
                adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        unique case (r_state)
            CV_IDLE: begin
                if (i_valid) begin
                    n_bin   = i_number;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = CV_RUN;
                end
            end
            CV_RUN: begin
                n_bcd = {adj[BCD_W-2:0], r_bin[NUMBER_WIDTH-1]};
                n_bin = {r_bin[NUMBER_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = CV_DONE;
                end
            end
            CV_DONE: begin
                if (i_ready) begin
                    n_state = CV_IDLE;
                end
            end
            default: n_state = CV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CV_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_ready = (r_state == CV_IDLE);
    assign o_valid = (r_state == CV_DONE);
    assign o_bcd   = r_bcd;

endmodule

>>> src/dpc_mirror.sv
// ----------------------------------------------------------------------------
// dpc_mirror: digit-serial mirror compare of a BCD value
// Left-aligns the digits, then compares top of that copy against bottom of
// the original, one digit per cycle.
// ----------------------------------------------------------------------------
module dpc_mirror #(
    parameter int unsigned NUM_DIGITS = dpc_pkg::dec_digits(dpc_pkg::NUMBER_WIDTH_DEF)
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [NUM_DIGITS*dpc_pkg::DIGIT_W-1:0]   i_bcd,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic                                     o_match
);
    import dpc_pkg::*;

    localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;
    localparam int unsigned CNT_W = $clog2(NUM_DIGITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_DIGITS - 1);

    t_mr_state          r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [BCD_W-1:0]   r_orig, n_orig;
    logic [BCD_W-1:0]   r_norm, n_norm;
    logic               r_match, n_match;
    logic [DIGIT_W-1:0] top_dig, bot_dig;

    assign top_dig = r_norm[BCD_W-1 -: DIGIT_W];
    assign bot_dig = r_orig[DIGIT_W-1:0];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_orig  = r_orig;
        n_norm  = r_norm;
        n_match = r_match;
        unique case (r_state)
            MR_IDLE: begin
                if (i_valid) begin
                    n_orig  = i_bcd;
                    n_norm  = i_bcd;
                    n_cnt   = '0;
                    n_state = MR_NORM;
                end
            end
            MR_NORM: begin
                // all-zero value stops after NUM_DIGITS-1 shifts and matches
                if (top_dig == DIGIT_ZERO && r_cnt != CNT_LAST) begin
                    n_norm = {r_norm[BCD_W-DIGIT_W-1:0], DIGIT_ZERO};
                    n_cnt  = r_cnt + 1'b1;
                end else begin
                    n_cnt   = '0;
                    n_match = 1'b1;
                    n_state = MR_CMP;
                end
            end
            MR_CMP: begin
                // past the digit count both sides read zero, so a full sweep is safe
                n_match = r_match & (top_dig == bot_dig);
                n_norm  = {r_norm[BCD_W-DIGIT_W-1:0], DIGIT_ZERO};
                n_orig  = {DIGIT_ZERO, r_orig[BCD_W-1:DIGIT_W]};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = MR_DONE;
                end
            end
            MR_DONE: begin
                if (i_ready) begin
                    n_state = MR_IDLE;
                end
            end
            default: n_state = MR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MR_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_orig  <= n_orig;
        r_norm  <= n_norm;
        r_match <= n_match;
    end

    assign o_ready = (r_state == MR_IDLE);
    assign o_valid = (r_state == MR_DONE);
    assign o_match = r_match;

endmodule

>>> src/decimal_palindrome_check_top.sv
// ----------------------------------------------------------------------------
// decimal_palindrome_check_top: decimal palindrome test of an unsigned number
// Input beat: i_number, NUMBER_WIDTH bits. Output beat: o_is_palindrome.
// Channels: i_valid/o_stall in, o_valid/i_stall out; a beat moves when valid
// is high and stall is low at a rising edge. One result beat per input beat,
// in order.
// Datapath: a serial shift-and-add-3 converter turns the number into BCD, one
// binary bit per cycle. The BCD word then goes to a checker that left-aligns
// the digits (20 of them at 64 bits) and compares digit pairs, one per cycle.
// Converter and checker overlap: the converter takes a new number while the
// checker works on the last one, but only once it has handed its BCD word on.
// Without a receiver stall, the converter's bit-serial shift sets the pace.
// Zero reads as a palindrome; a nonzero number ending in 0 never matches.
// Reset (i_rst_n low, synchronous) drops all work in flight and empties the
// output register. When the receiver stalls, the result holds in the output
// register, the checker then holds, then the converter, and o_stall stays high.
// ----------------------------------------------------------------------------
module decimal_palindrome_check_top #(
    parameter int unsigned NUMBER_WIDTH = dpc_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_is_palindrome
);
    import dpc_pkg::*;

    localparam int unsigned NUM_DIGITS = dec_digits(NUMBER_WIDTH);
    localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;

    logic             cv_ready;
    logic             cv_valid;
    logic [BCD_W-1:0] cv_bcd;
    logic             mr_ready;
    logic             mr_valid;
    logic             mr_match;
    logic             out_free;

    logic             r_out_valid;
    logic             r_out_bit;

    // input side: the converter takes a beat only when idle
    assign o_stall = !cv_ready;

    dpc_bin2bcd #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .NUM_DIGITS   (NUM_DIGITS)
    ) u_bin2bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (cv_ready),
        .i_number (i_number),
        .o_valid  (cv_valid),
        .i_ready  (mr_ready),
        .o_bcd    (cv_bcd)
    );

    dpc_mirror #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_mirror (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cv_valid),
        .o_ready (mr_ready),
        .i_bcd   (cv_bcd),
        .o_valid (mr_valid),
        .i_ready (out_free),
        .o_match (mr_match)
    );

    // output register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (mr_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (mr_valid && out_free) begin
            r_out_bit <= mr_match;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_is_palindrome = r_out_bit;

endmodule

>>> tb/tb_decimal_palindrome_check_top.sv
// ----------------------------------------------------------------------------
// tb_decimal_palindrome_check_top: self-checking bench for the palindrome test
// Sends numbers through the valid/stall input channel, predicts each verdict
// with a digit-peeling model and checks every output beat against it in
// order. Directed edge values first, then mostly constructed palindromes and
// near misses, with random idle bursts on both channels and a clean tail.
// ----------------------------------------------------------------------------
module tb_decimal_palindrome_check_top;

    import dpc_pkg::*;

    localparam int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF;
    localparam int unsigned DEC_BASE     = 10;
    localparam int unsigned MAX_DIGITS   = 20;   // decimal digits of 2^64-1
    // idle time after the last verdict, as a margin
    localparam int unsigned DRAIN_CYCLES = 160;
    // watchdog limit for ~1000 beats, with a wide margin
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [NUMBER_WIDTH-1:0] i_number = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic                    o_is_palindrome;

    decimal_palindrome_check_top #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_number       (i_number),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_palindrome(o_is_palindrome)
    );

    // verdicts still owed by the block, oldest first
    bit          verdict_q[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    // random idling on both channels; cleared for quiet stretches and the tail
    bit          idling_on   = 1'b1;
    int unsigned stall_left  = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Verdict predictor: peel low digits into a reversed half until it meets
    // or passes the remaining high part, then compare the halves (drop the
    // middle digit for odd lengths). Zero passes, a trailing 0 fails.
    // ------------------------------------------------------------------------
    function automatic bit mirror_verdict(input logic [NUMBER_WIDTH-1:0] number);
        longint unsigned upper;
        longint unsigned rev;
        upper = 64'(number);
        rev   = 0;
        if (upper == 0)
            return 1'b1;
        if (upper % DEC_BASE == 0)
            return 1'b0;
        while (upper > rev) begin
            rev   = rev * DEC_BASE + upper % DEC_BASE;
            upper = upper / DEC_BASE;
        end
        return (upper == rev) || (upper == rev / DEC_BASE);
    endfunction

    function automatic logic [63:0] pow10(input int unsigned exp10);
        logic [63:0] acc;
        acc = 64'd1;
        repeat (exp10) acc = acc * DEC_BASE;
        return acc;
    endfunction

    // random palindrome of ndig digits, redrawn until it fits in 64 bits
    function automatic logic [63:0] random_mirror(input int unsigned ndig);
        logic [127:0] acc;
        int unsigned  dig[MAX_DIGITS];
        int unsigned  k;
        do begin
            acc = '0;
            for (k = 0; k < ndig; k++)
                dig[k] = $urandom_range(0, 9);
            dig[0] = (ndig == MAX_DIGITS) ? 1 : $urandom_range(1, 9);
            for (k = 0; k < ndig / 2; k++)
                dig[ndig-1-k] = dig[k];
            for (k = 0; k < ndig; k++)
                acc = acc * DEC_BASE + dig[k];
        end while (acc > {64'd0, U64_MAX});
        return acc[63:0];
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one input beat. An optional idle burst goes first, with junk on
    // the bus while valid is low. Returns just after the accepting edge, so
    // back-to-back calls keep valid high without a second assignment.
    // ------------------------------------------------------------------------
    task automatic send_number(input logic [63:0] number);
        int unsigned gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_valid  <= 1'b0;
            i_number <= {$urandom, $urandom};
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_number <= number[NUMBER_WIDTH-1:0];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        verdict_q.push_back(mirror_verdict(number[NUMBER_WIDTH-1:0]));
    endtask

    // ------------------------------------------------------------------------
    // Receiver back-pressure: random stall bursts while idling is on. Reads are
    // taken right after the edge, i.e. the values the block sampled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (idling_on && i_rst_n && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 7);
        i_stall <= (stall_left > 0);
    end

    // output checker: every accepted result beat against the oldest verdict
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                $error("result beat with nothing expected: is_palindrome=%0b",
                       o_is_palindrome);
                error_count++;
            end else begin
                want = verdict_q.pop_front();
                if (o_is_palindrome !== want) begin
                    $error("is_palindrome mismatch: expected %0b, actual %0b",
                           want, o_is_palindrome);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // zero, single digits, the width's extremes, a lone bit and alternating bit patterns
    task automatic test_edge_values();
        send_number(64'd0);
        send_number(64'd1);
        send_number(64'd9);
        send_number(U64_MAX);                    // 20 digits, not mirrored
        send_number(64'd18446744066044764481);   // largest 64-bit palindrome
        send_number(64'h8000_0000_0000_0000);
        send_number(64'h5555_5555_5555_5555);
        send_number(64'hAAAA_AAAA_AAAA_AAAA);
        send_number(64'd9999999999999999999);    // 19 nines
    endtask

    // nonzero values ending in 0 never match, even when otherwise mirrored
    task automatic test_trailing_zero();
        send_number(64'd10);
        send_number(64'd100);
        send_number(64'd1210);
        send_number(64'd10000000000000000000);
        send_number(64'd18446744073709551610);
    endtask

    // odd and even lengths, with near misses on either side
    task automatic test_mirror_shapes();
        send_number(64'd11);
        send_number(64'd12);
        send_number(64'd121);
        send_number(64'd1221);
        send_number(64'd1231);
        send_number(64'd12321);
        send_number(64'd12331);
        send_number(64'd10000000000000000001);
        send_number(64'd1000000000000000001);
        send_number(64'd99);
    endtask

    // half constructed palindromes of every length, plus near misses,
    // trailing zeros, short random values and raw 64-bit noise; idling is
    // switched on and off per block so quiet stretches also occur
    task automatic test_random_mix(input int unsigned count);
        logic [63:0] value;
        int unsigned ndig;
        int unsigned n;
        for (n = 0; n < count; n++) begin
            if (n % 50 == 0)
                idling_on = ($urandom_range(0, 3) != 0);
            ndig = $urandom_range(1, MAX_DIGITS);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: value = random_mirror(ndig);
                5: value = random_mirror(ndig) + pow10($urandom_range(0, ndig - 1));
                6: value = random_mirror(ndig) ^ (64'd1 << $urandom_range(0, 63));
                7: begin
                    value = {$urandom, $urandom};
                    value = value - value % DEC_BASE;
                end
                8: value = (ndig == MAX_DIGITS) ? {$urandom, $urandom}
                                                : {$urandom, $urandom} % pow10(ndig);
                default: value = {$urandom, $urandom};
            endcase
            send_number(value);
        end
    endtask

    // full-rate tail with neither side idling
    task automatic test_back_to_back(input int unsigned count);
        int unsigned n;
        idling_on = 1'b0;
        for (n = 0; n < count; n++)
            send_number((n % 2 == 0) ? random_mirror($urandom_range(1, MAX_DIGITS))
                                     : {$urandom, $urandom});
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_values();
        test_trailing_zero();
        test_mirror_shapes();
        test_random_mix(900);
        test_back_to_back(80);

        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && verdict_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
